// ===== hdl/rlpe_pkg.sv =====
// ============================================================================
// rlpe_pkg
// Shared types and constants for the rainbow LED pulse encoder.
// ============================================================================
package rlpe_pkg;

    // Rainbow period in ms, one full hue turn
    localparam int RAINBOW_PERIOD_MS = 12000;

    // Period as a signal-width constant
    localparam logic [15:0] PERIOD = 16'(RAINBOW_PERIOD_MS);

    // Bits needed for a remainder below the period
    localparam int PW  = $clog2(RAINBOW_PERIOD_MS);
    // Remainder before its single correction (below twice the period)
    localparam int RAW = PW + 1;
    // Width of remainder * 360
    localparam int XW  = PW + 9;
    // Reciprocal shift and width of the quotient estimate of t / period
    localparam int K   = 31 + PW;
    localparam int QAW = 33 - PW;

    // floor(2^K / period): estimate is exact or one low for any 32-bit dividend
    localparam logic [63:0] RECIP_P_W = (64'd1 << K) / 64'(RAINBOW_PERIOD_MS);
    localparam logic [31:0] RECIP_P   = RECIP_P_W[31:0];

    // Period at remainder width, for the correction compare
    localparam logic [RAW-1:0] PER_R = RAW'(RAINBOW_PERIOD_MS);

    // Hue constants
    localparam logic [9:0]  DEG_FULL   = 10'd360;
    localparam logic [8:0]  DEG_SECTOR = 9'd60;

    // ceil(2^28 / 360): exact quotient for any 17-bit dividend
    localparam logic [19:0] RECIP_360  = 20'd745655;
    // ceil(2^20 / 60): exact quotient for any 14-bit dividend
    localparam logic [14:0] RECIP_60   = 15'd17477;

    // Words per LED and idle word
    localparam logic [4:0]  BITS_PER_LED = 5'd24;
    localparam logic [4:0]  WORDS_FRAME  = 5'd26;
    localparam logic [15:0] IDLE_WORD    = 16'h8000;
    localparam logic        POLARITY     = 1'b1;

    // Register indexes
    localparam logic [1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] REG_HUE_STEP   = 2'd1;
    localparam logic [1:0] REG_ONE_HIGH   = 2'd2;
    localparam logic [1:0] REG_ZERO_HIGH  = 2'd3;

    // Reset values
    localparam logic [7:0]  RST_BRIGHTNESS = 8'd30;
    localparam logic [8:0]  RST_HUE_STEP   = 9'd40;
    localparam logic [14:0] RST_ONE_HIGH   = 15'd13;
    localparam logic [14:0] RST_ZERO_HIGH  = 15'd6;

    // Hue sectors of the HSV wheel
    typedef enum logic [2:0] {
        SEC_R_TO_Y = 3'd0,
        SEC_Y_TO_G = 3'd1,
        SEC_G_TO_C = 3'd2,
        SEC_C_TO_B = 3'd3,
        SEC_B_TO_M = 3'd4,
        SEC_M_TO_R = 3'd5
    } t_sector;

    // One LED request
    typedef struct packed {
        logic [31:0] frame_time_ms;
        logic [7:0]  led_position;
        logic        last_led;
    } t_led_req;

    // One PWM sequence word
    typedef struct packed {
        logic [15:0] pwm_word;
        logic        last;
    } t_pwm_out;

endpackage

// ===== hdl/rainbow_led_pulse_encoder.sv =====
// ============================================================================
// rainbow_led_pulse_encoder
// Per-LED rainbow hue to GRB color to PWM sequence words, one word a cycle.
// ============================================================================
// An item is taken when start is high and busy is low. The hue and color math
// runs through a ten-stage pipeline, then the item is loaded into the word
// serializer. Words come out one per cycle on o_strobe: 24 per LED, 26 when
// last_led is set (two idle words follow). The serializer takes a new item
// only as it sends the last word of its current item, with no gaps between
// items while requests keep coming. Up to ten items may wait in the pipeline;
// busy rises when it is full and no item leaves it. Results cannot be held
// off: each word is valid for exactly one cycle.
module rainbow_led_pulse_encoder (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Item command channel
    input  logic                     start,
    input  rlpe_pkg::t_led_req       i_req,
    output logic                     busy,
    // Result channel
    output logic                     o_strobe,
    output rlpe_pkg::t_pwm_out       o_result,
    // Configuration port
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [3:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int NST = 10;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  r_brightness;
    logic [8:0]  r_hue_step;
    logic [14:0] r_one_high;
    logic [14:0] r_zero_high;
    logic        cfg_wr;
    logic [1:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brightness <= rlpe_pkg::RST_BRIGHTNESS;
            r_hue_step   <= rlpe_pkg::RST_HUE_STEP;
            r_one_high   <= rlpe_pkg::RST_ONE_HIGH;
            r_zero_high  <= rlpe_pkg::RST_ZERO_HIGH;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                rlpe_pkg::REG_BRIGHTNESS: r_brightness <= pwdata[7:0];
                rlpe_pkg::REG_HUE_STEP:   r_hue_step   <= pwdata[8:0];
                rlpe_pkg::REG_ONE_HIGH:   r_one_high   <= pwdata[14:0];
                rlpe_pkg::REG_ZERO_HIGH:  r_zero_high  <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (cfg_idx)
            rlpe_pkg::REG_BRIGHTNESS: prdata = {24'd0, r_brightness};
            rlpe_pkg::REG_HUE_STEP:   prdata = {23'd0, r_hue_step};
            rlpe_pkg::REG_ONE_HIGH:   prdata = {17'd0, r_one_high};
            rlpe_pkg::REG_ZERO_HIGH:  prdata = {17'd0, r_zero_high};
            default:                  prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic [1:NST] r_vld;
    logic [1:NST] adv;      // stage k may hand its item on
    logic         in_take;
    logic         ser_load;

    always_comb begin
        adv[NST] = ser_load;
        for (int k = NST - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k + 1] || adv[k + 1];
        end
    end

    assign busy    = r_vld[1] && !adv[1];
    assign in_take = !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (in_take) begin
                r_vld[1] <= start;
            end
            for (int k = 1; k < NST; k++) begin
                if (adv[k]) begin
                    r_vld[k + 1] <= r_vld[k];
                end
            end
        end
    end

    // last_led flag travels with each item
    logic [1:NST] r_lst;

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_lst[1] <= i_req.last_led;
        end
        for (int k = 1; k < NST; k++) begin
            if (adv[k]) begin
                r_lst[k + 1] <= r_lst[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath stage registers
    // ------------------------------------------------------------------
    logic [31:0]                r_t1;
    logic [7:0]                 r_pos1;
    logic [rlpe_pkg::QAW-1:0]   r_qa2;
    logic [31:0]                r_t2;
    logic [16:0]                r_y2;
    logic [rlpe_pkg::RAW-1:0]   r_ra3;
    logic [8:0]                 r_qh3;
    logic [16:0]                r_y3;
    logic [rlpe_pkg::XW-1:0]    r_x4;
    logic [8:0]                 r_rh4;
    logic [8:0]                 r_qb5;
    logic [rlpe_pkg::XW-1:0]    r_x5;
    logic [8:0]                 r_rh5;
    logic [rlpe_pkg::RAW-1:0]   r_rb6;
    logic [8:0]                 r_qb6;
    logic [8:0]                 r_rh6;
    logic [8:0]                 r_hue7;
    rlpe_pkg::t_sector          r_sec8;
    logic [5:0]                 r_rem8;
    rlpe_pkg::t_sector          r_sec9;
    logic [13:0]                r_rise9;
    logic [13:0]                r_fall9;
    rlpe_pkg::t_sector          r_sec10;
    logic [7:0]                 r_rise10;
    logic [7:0]                 r_fall10;

    // Next values
    logic [63:0]                prod_ta;
    logic [rlpe_pkg::QAW-1:0]   n_qa;
    logic [16:0]                n_y;
    logic [31:0]                ta_full;
    logic [rlpe_pkg::RAW-1:0]   n_ra;
    logic [36:0]                prod_yh;
    logic [8:0]                 n_qh;
    logic [rlpe_pkg::PW-1:0]    ra_fix;
    logic [rlpe_pkg::XW-1:0]    n_x;
    logic [16:0]                yh_full;
    logic [8:0]                 n_rh;
    logic [rlpe_pkg::XW+31:0]   prod_xb;
    logic [8:0]                 n_qb;
    logic [rlpe_pkg::XW-1:0]    xb_full;
    logic [rlpe_pkg::RAW-1:0]   n_rb;
    logic [9:0]                 base;
    logic [9:0]                 hue_sum;
    logic [8:0]                 n_hue;
    logic [2:0]                 sec_cnt;
    rlpe_pkg::t_sector          n_sec;
    logic [5:0]                 n_rem;
    logic [5:0]                 rem_c;
    logic [13:0]                n_rise9;
    logic [13:0]                n_fall9;
    logic [28:0]                prod_r;
    logic [28:0]                prod_f;

    // Stage 1 to 2: quotient estimate of t / period, position * hue step
    assign prod_ta = 64'(r_t1) * 64'(rlpe_pkg::RECIP_P);
    assign n_qa    = prod_ta[rlpe_pkg::K +: rlpe_pkg::QAW];
    assign n_y     = 17'(r_pos1) * 17'(r_hue_step);

    // Stage 2 to 3: raw remainder of t, exact quotient of y / 360
    assign ta_full = r_t2 - (32'(r_qa2) * 32'(rlpe_pkg::PERIOD));
    assign n_ra    = ta_full[rlpe_pkg::RAW-1:0];
    assign prod_yh = 37'(r_y2) * 37'(rlpe_pkg::RECIP_360);
    assign n_qh    = prod_yh[36:28];

    // Stage 3 to 4: corrected remainder times 360, y mod 360
    assign ra_fix  = (r_ra3 >= rlpe_pkg::PER_R) ? rlpe_pkg::PW'(r_ra3 - rlpe_pkg::PER_R)
                                                : rlpe_pkg::PW'(r_ra3);
    assign n_x     = rlpe_pkg::XW'(ra_fix) * rlpe_pkg::XW'(rlpe_pkg::DEG_FULL);
    assign yh_full = r_y3 - (17'(r_qh3) * 17'(rlpe_pkg::DEG_FULL));
    assign n_rh    = yh_full[8:0];

    // Stage 4 to 5: quotient estimate of x / period
    assign prod_xb = (rlpe_pkg::XW + 32)'(r_x4) * (rlpe_pkg::XW + 32)'(rlpe_pkg::RECIP_P);
    assign n_qb    = prod_xb[rlpe_pkg::K +: 9];

    // Stage 5 to 6: raw remainder of x
    assign xb_full = r_x5 - (rlpe_pkg::XW'(r_qb5) * rlpe_pkg::XW'(rlpe_pkg::PERIOD));
    assign n_rb    = xb_full[rlpe_pkg::RAW-1:0];

    // Stage 6 to 7: base hue correction, add position offset, wrap at 360
    assign base    = 10'(r_qb6) + ((r_rb6 >= rlpe_pkg::PER_R) ? 10'd1 : 10'd0);
    assign hue_sum = base + 10'(r_rh6);
    assign n_hue   = (hue_sum >= rlpe_pkg::DEG_FULL) ? 9'(hue_sum - rlpe_pkg::DEG_FULL)
                                                     : hue_sum[8:0];

    // Stage 7 to 8: sector and offset within it
    assign sec_cnt = 3'(r_hue7 >= 9'd60)  + 3'(r_hue7 >= 9'd120) + 3'(r_hue7 >= 9'd180)
                   + 3'(r_hue7 >= 9'd240) + 3'(r_hue7 >= 9'd300);
    assign n_sec   = rlpe_pkg::t_sector'(sec_cnt);
    assign n_rem   = 6'(r_hue7 - (9'(sec_cnt) * rlpe_pkg::DEG_SECTOR));

    // Stage 8 to 9: value times rising and falling fractions
    assign rem_c   = 6'(rlpe_pkg::DEG_SECTOR) - r_rem8;
    assign n_rise9 = 14'(r_brightness) * 14'(r_rem8);
    assign n_fall9 = 14'(r_brightness) * 14'(rem_c);

    // Stage 9 to 10: divide by 60
    assign prod_r  = 29'(r_rise9) * 29'(rlpe_pkg::RECIP_60);
    assign prod_f  = 29'(r_fall9) * 29'(rlpe_pkg::RECIP_60);

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_t1   <= i_req.frame_time_ms;
            r_pos1 <= i_req.led_position;
        end
        if (adv[1]) begin
            r_qa2 <= n_qa;
            r_t2  <= r_t1;
            r_y2  <= n_y;
        end
        if (adv[2]) begin
            r_ra3 <= n_ra;
            r_qh3 <= n_qh;
            r_y3  <= r_y2;
        end
        if (adv[3]) begin
            r_x4  <= n_x;
            r_rh4 <= n_rh;
        end
        if (adv[4]) begin
            r_qb5 <= n_qb;
            r_x5  <= r_x4;
            r_rh5 <= r_rh4;
        end
        if (adv[5]) begin
            r_rb6 <= n_rb;
            r_qb6 <= r_qb5;
            r_rh6 <= r_rh5;
        end
        if (adv[6]) begin
            r_hue7 <= n_hue;
        end
        if (adv[7]) begin
            r_sec8 <= n_sec;
            r_rem8 <= n_rem;
        end
        if (adv[8]) begin
            r_sec9  <= r_sec8;
            r_rise9 <= n_rise9;
            r_fall9 <= n_fall9;
        end
        if (adv[9]) begin
            r_sec10  <= r_sec9;
            r_rise10 <= prod_r[27:20];
            r_fall10 <= prod_f[27:20];
        end
    end

    // ------------------------------------------------------------------
    // Sector to GRB
    // ------------------------------------------------------------------
    logic [7:0]  col_g;
    logic [7:0]  col_r;
    logic [7:0]  col_b;

    always_comb begin
        col_g = '0;
        col_r = '0;
        col_b = '0;
        unique case (r_sec10)
            rlpe_pkg::SEC_R_TO_Y: begin
                col_r = r_brightness;
                col_g = r_rise10;
            end
            rlpe_pkg::SEC_Y_TO_G: begin
                col_r = r_fall10;
                col_g = r_brightness;
            end
            rlpe_pkg::SEC_G_TO_C: begin
                col_g = r_brightness;
                col_b = r_rise10;
            end
            rlpe_pkg::SEC_C_TO_B: begin
                col_g = r_fall10;
                col_b = r_brightness;
            end
            rlpe_pkg::SEC_B_TO_M: begin
                col_r = r_rise10;
                col_b = r_brightness;
            end
            default: begin
                col_r = r_brightness;
                col_b = r_fall10;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Word serializer
    // ------------------------------------------------------------------
    logic        r_ser_act;
    logic [23:0] r_grb;
    logic [4:0]  r_cnt;
    logic        r_ser_lst;
    logic        n_ser_act;
    logic [23:0] n_grb;
    logic [4:0]  n_cnt;
    logic        n_ser_lst;
    logic        ser_done;
    logic [4:0]  ser_total;
    logic [15:0] n_word;

    assign ser_total = r_ser_lst ? rlpe_pkg::WORDS_FRAME : rlpe_pkg::BITS_PER_LED;
    assign ser_done  = r_ser_act && (r_cnt == ser_total - 5'd1);
    assign ser_load  = !r_ser_act || ser_done;

    // Word for the current count
    always_comb begin
        if (r_cnt < rlpe_pkg::BITS_PER_LED) begin
            n_word = r_grb[23] ? {rlpe_pkg::POLARITY, r_one_high}
                               : {rlpe_pkg::POLARITY, r_zero_high};
        end else begin
            n_word = rlpe_pkg::IDLE_WORD;
        end
    end

    // Serializer next state
    always_comb begin
        n_ser_act = r_ser_act;
        n_grb     = {r_grb[22:0], 1'b0};
        n_cnt     = r_cnt + 5'd1;
        n_ser_lst = r_ser_lst;
        if (ser_load && r_vld[NST]) begin
            n_ser_act = 1'b1;
            n_grb     = {col_g, col_r, col_b};
            n_cnt     = '0;
            n_ser_lst = r_lst[NST];
        end else if (ser_done) begin
            n_ser_act = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_act <= 1'b0;
            o_strobe  <= 1'b0;
        end else begin
            r_ser_act <= n_ser_act;
            o_strobe  <= r_ser_act;
        end
    end

    always_ff @(posedge i_clk) begin
        r_grb             <= n_grb;
        r_cnt             <= n_cnt;
        r_ser_lst         <= n_ser_lst;
        o_result.pwm_word <= n_word;
        o_result.last     <= ser_done;
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Every active serializer cycle yields exactly one word next cycle
    a_ser_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ser_act |=> o_strobe)
        else $error("serializer active without an output word");

    // Serializer only starts on a valid item from the last stage
    a_load_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ser_act) |-> $past(r_vld[NST]))
        else $error("serializer started without a pipeline item");

    // Every emitted word carries the polarity bit
    a_polarity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> o_result.pwm_word[15])
        else $error("output word without polarity bit");

    // A taken command always lands in the first stage
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> r_vld[1])
        else $error("accepted item lost at pipeline entry");

    // End-of-item marker only on a real word
    a_last_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ser_done |=> (o_strobe && o_result.last))
        else $error("item end marker missing");

endmodule
